>>> rtl/dpr_pkg.sv
// shared types, register codes and reset values for the disparity reprojector
// no dependencies; imported by dpr_div_pipe, the core top level and the testbench
`default_nettype none

package dpr_pkg;

  // field widths
  localparam int DISP_W  = 16;
  localparam int PIX_W   = 12;
  localparam int PT_W    = 11;
  localparam int COORD_W = 28;
  localparam int DEPTH_W = 27;
  localparam int CAL_W   = 20;
  localparam int LIMIT_W = 27;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 27;

  // quotient bits produced by each divider (a larger quotient raises the overflow flag)
  localparam int QUOT_W = 27;

  // defaults for top level parameters
  localparam int IMAGE_DIM_MAX_DEF = 4096;
  localparam int DIV_STEP_BITS_DEF = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd6;

  // register reset values
  localparam logic [CAL_W-1:0]   FOCAL_X_RST  = 20'd137062;
  localparam logic [CAL_W-1:0]   FOCAL_Y_RST  = 20'd138035;
  localparam logic [CAL_W-1:0]   CENTER_X_RST = 20'd81946;
  localparam logic [CAL_W-1:0]   CENTER_Y_RST = 20'd63386;
  localparam logic [CAL_W-1:0]   BASELINE_RST = 20'd65000;
  localparam logic [LIMIT_W-1:0] NEAR_RST     = 27'd500000;
  localparam logic [LIMIT_W-1:0] FAR_RST      = 27'd15000000;

  typedef struct packed {
    logic signed [DISP_W-1:0] disparity_q4;
    logic [PIX_W-1:0]         pixel_col;
    logic [PIX_W-1:0]         pixel_row;
  } dpr_in_t;

  typedef struct packed {
    logic [PT_W-1:0]           point_col;
    logic [PT_W-1:0]           point_row;
    logic                      point_valid;
    logic signed [COORD_W-1:0] x_um;
    logic signed [COORD_W-1:0] y_um;
    logic [DEPTH_W-1:0]        z_um;
  } dpr_out_t;

  // sideband carried through the depth divider
  typedef struct packed {
    logic             disp_pos;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } dpr_zside_t;

  // sideband carried through the lateral dividers
  typedef struct packed {
    logic               ok;
    logic               neg;
    logic [DEPTH_W-1:0] z;
    logic [PT_W-1:0]    point_col;
    logic [PT_W-1:0]    point_row;
  } dpr_lside_t;

endpackage

`default_nettype wire

>>> rtl/dpr_div_pipe.sv
// pipelined restoring divider with quotient overflow flag and sideband
// uses dpr_pkg for parameter defaults
`default_nettype none

module dpr_div_pipe
  import dpr_pkg::*;
#(
  parameter int NUM_W     = 47,
  parameter int DEN_W     = 20,
  parameter int Q_W       = QUOT_W,
  parameter int STEP_BITS = DIV_STEP_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              src_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side,
  output logic                   res_valid,
  output logic [Q_W-1:0]         quot,
  output logic                   ovf,
  output logic [SIDE_W-1:0]      res_side
);

  localparam int NSTG = (Q_W + STEP_BITS - 1) / STEP_BITS;

  logic              vld_q  [NSTG];
  logic              ovf_q  [NSTG];
  logic [DEN_W-1:0]  rem_q  [NSTG];
  logic [Q_W-1:0]    work_q [NSTG];
  logic [DEN_W-1:0]  den_q  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int FIRST = s * STEP_BITS;
    localparam int STEPS = (Q_W - FIRST < STEP_BITS) ? (Q_W - FIRST) : STEP_BITS;

    logic              vld_in;
    logic              ovf_in;
    logic [DEN_W-1:0]  rem_in;
    logic [Q_W-1:0]    work_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W-1:0]  rem_c;
    logic [Q_W-1:0]    work_c;
    logic [DEN_W:0]    trial;

    if (s == 0) begin : g_head
      // quotient overflows its width when the upper numerator part reaches the divisor
      assign vld_in  = src_valid;
      assign rem_in  = DEN_W'(num[NUM_W-1:Q_W]);
      assign ovf_in  = (DEN_W'(num[NUM_W-1:Q_W]) >= den);
      assign work_in = num[Q_W-1:0];
      assign den_in  = den;
      assign side_in = side;
    end else begin : g_body
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign ovf_in  = ovf_q[s-1];
      assign work_in = work_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // numerator bits shift out the top of work, quotient bits shift in the bottom
    always_comb begin
      rem_c  = rem_in;
      work_c = work_in;
      trial  = '0;
      for (int k = 0; k < STEPS; k++) begin
        trial = {rem_c, work_c[Q_W-1]};
        if (trial >= {1'b0, den_in}) begin
          trial  = trial - {1'b0, den_in};
          work_c = {work_c[Q_W-2:0], 1'b1};
        end else begin
          work_c = {work_c[Q_W-2:0], 1'b0};
        end
        rem_c = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_q[s]  <= ovf_in;
        rem_q[s]  <= rem_c;
        work_q[s] <= work_c;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign res_valid = vld_q[NSTG-1];
  assign quot      = work_q[NSTG-1];
  assign ovf       = ovf_q[NSTG-1];
  assign res_side  = side_q[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/disparity_to_point_reprojector_core.sv
// disparity to 3d point reprojector, one item per clock
// path: input reg, depth divider, offset reg, product reg, lateral dividers, output reg;
// the two chained 27-bit restoring dividers resolve DIV_STEP_BITS quotient bits per stage
// throughput: one item per cycle while pt_ready is high; the whole pipe holds on a stall
// reset (synchronous rst): pipeline empties, calibration registers return to defaults
`default_nettype none

module disparity_to_point_reprojector_core
  import dpr_pkg::*;
#(
  parameter int IMAGE_DIM_MAX = IMAGE_DIM_MAX_DEF,
  parameter int DIV_STEP_BITS = DIV_STEP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // disparity pixel stream
  input  wire logic                  pix_valid,
  output logic                       pix_ready,
  input  wire dpr_in_t               pix,
  // point stream
  output logic                       pt_valid,
  input  wire logic                  pt_ready,
  output dpr_out_t                   pt,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_W = 17;
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(IMAGE_DIM_MAX);
  localparam int PROD_W = 2 * CAL_W;          // focal_x * baseline
  localparam int ZNUM_W = PROD_W - 4;         // disparity is in sixteenths
  localparam int ZDEN_W = DISP_W - 1;         // positive disparity magnitude
  localparam int OFF_W  = CAL_W + 1;          // signed pixel offset, 12.8
  localparam int LNUM_W = CAL_W + DEPTH_W;    // |offset| * z

  // ---------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------
  logic [CAL_W-1:0]   focal_x, focal_y, center_x, center_y, baseline_um;
  logic [LIMIT_W-1:0] near_limit_um, far_limit_um;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= FOCAL_X_RST;
      focal_y       <= FOCAL_Y_RST;
      center_x      <= CENTER_X_RST;
      center_y      <= CENTER_Y_RST;
      baseline_um   <= BASELINE_RST;
      near_limit_um <= NEAR_RST;
      far_limit_um  <= FAR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x       <= cfg_data[CAL_W-1:0];
        REG_FOCAL_Y:  focal_y       <= cfg_data[CAL_W-1:0];
        REG_CENTER_X: center_x      <= cfg_data[CAL_W-1:0];
        REG_CENTER_Y: center_y      <= cfg_data[CAL_W-1:0];
        REG_BASELINE: baseline_um   <= cfg_data[CAL_W-1:0];
        REG_NEAR:     near_limit_um <= cfg_data[LIMIT_W-1:0];
        REG_FAR:      far_limit_um  <= cfg_data[LIMIT_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // depth numerator depends only on calibration, so it is kept up to date every cycle;
  // the user changes registers only while the pipe is empty, not enforced by the block
  logic [PROD_W-1:0] zprod;

  always_ff @(posedge clk) begin
    zprod <= focal_x * baseline_um;
  end

  // ---------------------------------------------------------------
  // global pipeline advance: everything moves unless the output holds a
  // result that has not been taken
  // ---------------------------------------------------------------
  logic en;

  assign en        = !pt_valid || pt_ready;
  assign pix_ready = en;

  // ---------------------------------------------------------------
  // stage a: input register, odd or out-of-range pixels travel as bubbles
  // ---------------------------------------------------------------
  logic    a_vld;
  dpr_in_t a_pix;
  logic    keep;

  assign keep = !pix.pixel_col[0] && !pix.pixel_row[0] &&
                ({5'd0, pix.pixel_col} < DIM_LIMIT) &&
                ({5'd0, pix.pixel_row} < DIM_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= pix_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pix <= pix;
    end
  end

  // ---------------------------------------------------------------
  // depth divider: z = (focal_x*baseline/16) / disparity
  // a quotient of 2^27 or more is beyond any far limit, so only the flag is kept
  // ---------------------------------------------------------------
  dpr_zside_t         zside_in, zside_out;
  logic               z_vld, z_ovf;
  logic [DEPTH_W-1:0] z_quot;

  assign zside_in.disp_pos = !a_pix.disparity_q4[DISP_W-1] && (a_pix.disparity_q4 != '0);
  assign zside_in.col      = a_pix.pixel_col;
  assign zside_in.row      = a_pix.pixel_row;

  dpr_div_pipe #(
    .NUM_W     (ZNUM_W),
    .DEN_W     (ZDEN_W),
    .Q_W       (DEPTH_W),
    .STEP_BITS (DIV_STEP_BITS),
    .SIDE_W    ($bits(dpr_zside_t))
  ) u_zdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (a_vld),
    .num       (zprod[PROD_W-1:4]),
    .den       (a_pix.disparity_q4[ZDEN_W-1:0]),
    .side      (zside_in),
    .res_valid (z_vld),
    .quot      (z_quot),
    .ovf       (z_ovf),
    .res_side  (zside_out)
  );

  // ---------------------------------------------------------------
  // stage c: depth range check and pixel offsets from the image center
  // ---------------------------------------------------------------
  logic               c_vld, c_ok, c_negx, c_negy;
  logic [DEPTH_W-1:0] c_z;
  logic [CAL_W-1:0]   c_magx, c_magy;
  logic [PT_W-1:0]    c_pcol, c_prow;
  logic               ok_next;
  logic [OFF_W-1:0]   offx, offy, offx_neg, offy_neg;

  assign ok_next = zside_out.disp_pos && !z_ovf &&
                   (z_quot > near_limit_um) && (z_quot < far_limit_um);

  assign offx     = {1'b0, zside_out.col, 8'd0} - {1'b0, center_x};
  assign offy     = {1'b0, zside_out.row, 8'd0} - {1'b0, center_y};
  assign offx_neg = -offx;
  assign offy_neg = -offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= z_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ok   <= ok_next;
      c_z    <= z_quot;
      c_negx <= offx[OFF_W-1];
      c_negy <= offy[OFF_W-1];
      c_magx <= offx[OFF_W-1] ? offx_neg[CAL_W-1:0] : offx[CAL_W-1:0];
      c_magy <= offy[OFF_W-1] ? offy_neg[CAL_W-1:0] : offy[CAL_W-1:0];
      c_pcol <= zside_out.col[PIX_W-1:1];
      c_prow <= zside_out.row[PIX_W-1:1];
    end
  end

  // ---------------------------------------------------------------
  // stage d: |offset| * z, sign kept aside so division truncates toward zero
  // ---------------------------------------------------------------
  logic              d_vld;
  logic [LNUM_W-1:0] d_px, d_py;
  dpr_lside_t        d_side;
  logic              d_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_px             <= c_magx * c_z;
      d_py             <= c_magy * c_z;
      d_side.ok        <= c_ok;
      d_side.neg       <= c_negx;
      d_side.z         <= c_z;
      d_side.point_col <= c_pcol;
      d_side.point_row <= c_prow;
      d_negy           <= c_negy;
    end
  end

  // ---------------------------------------------------------------
  // lateral dividers, x and y in lockstep; a zero focal length divides by one
  // ---------------------------------------------------------------
  logic [CAL_W-1:0]   den_x, den_y;
  logic               x_vld, y_vld, x_ovf, y_ovf, y_neg;
  logic [QUOT_W-1:0]  x_quot, y_quot;
  dpr_lside_t         x_side;

  assign den_x = (focal_x == '0) ? CAL_W'(1) : focal_x;
  assign den_y = (focal_y == '0) ? CAL_W'(1) : focal_y;

  dpr_div_pipe #(
    .NUM_W     (LNUM_W),
    .DEN_W     (CAL_W),
    .Q_W       (QUOT_W),
    .STEP_BITS (DIV_STEP_BITS),
    .SIDE_W    ($bits(dpr_lside_t))
  ) u_xdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (d_vld),
    .num       (d_px),
    .den       (den_x),
    .side      (d_side),
    .res_valid (x_vld),
    .quot      (x_quot),
    .ovf       (x_ovf),
    .res_side  (x_side)
  );

  dpr_div_pipe #(
    .NUM_W     (LNUM_W),
    .DEN_W     (CAL_W),
    .Q_W       (QUOT_W),
    .STEP_BITS (DIV_STEP_BITS),
    .SIDE_W    (1)
  ) u_ydiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (d_vld),
    .num       (d_py),
    .den       (den_y),
    .side      (d_negy),
    .res_valid (y_vld),
    .quot      (y_quot),
    .ovf       (y_ovf),
    .res_side  (y_neg)
  );

  // restore sign and saturate to 28 bits
  function automatic logic signed [COORD_W-1:0] lat_sat(input logic neg,
                                                        input logic [QUOT_W-1:0] mag,
                                                        input logic over);
    logic signed [COORD_W-1:0] v;
    v = $signed({1'b0, mag});
    if (neg) begin
      lat_sat = over ? {1'b1, {(COORD_W-1){1'b0}}} : -v;
    end else begin
      lat_sat = over ? {1'b0, {(COORD_W-1){1'b1}}} : v;
    end
  endfunction

  // ---------------------------------------------------------------
  // output register, invalid points carry zeros in x, y and z
  // ---------------------------------------------------------------
  dpr_out_t out_next;

  always_comb begin
    out_next.point_col   = x_side.point_col;
    out_next.point_row   = x_side.point_row;
    out_next.point_valid = x_side.ok;
    out_next.x_um        = x_side.ok ? lat_sat(x_side.neg, x_quot, x_ovf) : '0;
    out_next.y_um        = x_side.ok ? lat_sat(y_neg, y_quot, y_ovf) : '0;
    out_next.z_um        = x_side.ok ? x_side.z : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (en) begin
      pt_valid <= x_vld && y_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for disparity_to_point_reprojector_core
// predicts every point from its own copy of the calibration registers and compares per field
// depends on dpr_pkg and the core rtl only
module tb_top;
  import dpr_pkg::*;

  // pipeline depth estimate, used by wait_quiet to size its flush
  localparam int PIPE_LATENCY = 3 + 2 * ((QUOT_W + DIV_STEP_BITS_DEF - 1) / DIV_STEP_BITS_DEF);
  localparam int IMAGE_DIM    = IMAGE_DIM_MAX_DEF;
  localparam longint COORD_HI = 134217727;
  localparam longint COORD_LO = -134217728;
  // index past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 255;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  pix_valid;
  logic                  pix_ready;
  dpr_in_t               pix;
  logic                  pt_valid;
  logic                  pt_ready;
  dpr_out_t              pt;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // calibration as the testbench believes the core holds it
  logic [CAL_W-1:0]   cal_fx, cal_fy, cal_cx, cal_cy, cal_base;
  logic [LIMIT_W-1:0] lim_near, lim_far;

  // points predicted but not yet seen at the output, oldest first
  dpr_out_t pending_points[$];
  int       mismatches = 0;

  // random idling switches for the pixel sender and the point receiver
  bit idle_tx = 1'b0;
  bit idle_rx = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  disparity_to_point_reprojector_core dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // register write as the core applies it: masked to the register width,
  // anything past the list is dropped
  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FOCAL_X:  cal_fx   = val[CAL_W-1:0];
      REG_FOCAL_Y:  cal_fy   = val[CAL_W-1:0];
      REG_CENTER_X: cal_cx   = val[CAL_W-1:0];
      REG_CENTER_Y: cal_cy   = val[CAL_W-1:0];
      REG_BASELINE: cal_base = val[CAL_W-1:0];
      REG_NEAR:     lim_near = val[LIMIT_W-1:0];
      REG_FAR:      lim_far  = val[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // depth in micrometers, zero for a disparity that is not positive
  // focal is pixels*256 and disparity pixels*16, so the 16 is what is left over
  function automatic longint unsigned depth_um(logic signed [DISP_W-1:0] d);
    if (d <= 0) return 0;
    return (longint'(cal_fx) * longint'(cal_base)) / (16 * longint'(d));
  endfunction

  // (pos*256 - center) * z / focal, truncated toward zero, saturated to the coord width
  // a zero focal divides by one
  function automatic logic [COORD_W-1:0] lateral_um(logic [PIX_W-1:0] pos,
                                                    logic [CAL_W-1:0] ctr, longint z,
                                                    logic [CAL_W-1:0] focal);
    longint q;
    q = (longint'(pos) * 256 - longint'(ctr)) * z /
        ((focal == '0) ? 64'sd1 : longint'(focal));
    if (q > COORD_HI) q = COORD_HI;
    else if (q < COORD_LO) q = COORD_LO;
    return q[COORD_W-1:0];
  endfunction

  // returns 1 when the pixel produces a point, with the point in want
  function automatic bit reproject(dpr_in_t px, output dpr_out_t want);
    longint unsigned z;
    want = '0;
    // only even columns and rows inside the image make a point
    if (px.pixel_col[0] || px.pixel_row[0]) return 1'b0;
    if (int'(px.pixel_col) >= IMAGE_DIM || int'(px.pixel_row) >= IMAGE_DIM) return 1'b0;
    want.point_col = px.pixel_col[PIX_W-1:1];
    want.point_row = px.pixel_row[PIX_W-1:1];
    z = depth_um(px.disparity_q4);
    // depth must lie strictly inside the window; no disparity means z = 0, never inside
    if (z <= lim_near || z >= lim_far) return 1'b1;
    want.point_valid = 1'b1;
    want.z_um = z[DEPTH_W-1:0];
    want.x_um = lateral_um(px.pixel_col, cal_cx, longint'(z), cal_fx);
    want.y_um = lateral_um(px.pixel_row, cal_cy, longint'(z), cal_fy);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic compare_point(dpr_out_t got);
    dpr_out_t want;
    if (pending_points.size() == 0) begin
      mismatches++;
      $error("point with nothing predicted: col %0d row %0d", got.point_col, got.point_row);
      return;
    end
    want = pending_points.pop_front();
    if (got.point_col !== want.point_col) begin
      mismatches++;
      $error("point_col: expected %0d, actual %0d", want.point_col, got.point_col);
    end
    if (got.point_row !== want.point_row) begin
      mismatches++;
      $error("point_row: expected %0d, actual %0d", want.point_row, got.point_row);
    end
    if (got.point_valid !== want.point_valid) begin
      mismatches++;
      $error("point_valid: expected %0d, actual %0d", want.point_valid, got.point_valid);
    end
    if (got.x_um !== want.x_um) begin
      mismatches++;
      $error("x_um: expected %0d, actual %0d", want.x_um, got.x_um);
    end
    if (got.y_um !== want.y_um) begin
      mismatches++;
      $error("y_um: expected %0d, actual %0d", want.y_um, got.y_um);
    end
    if (got.z_um !== want.z_um) begin
      mismatches++;
      $error("z_um: expected %0d, actual %0d", want.z_um, got.z_um);
    end
  endtask

  // sample the point stream at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (!rst && pt_valid && pt_ready) compare_point(pt);
  end

  // receiver: ready drops for random-length bursts while idle_rx is set
  initial begin
    pt_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_rx && $urandom_range(0, 5) == 0) begin
        pt_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pt_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // valid is left high after the item goes in so back-to-back items never
  // lower and raise it in one step; wait_quiet drops it
  task automatic send_pixel(dpr_in_t item);
    dpr_out_t want;
    if (idle_tx && $urandom_range(0, 3) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= item;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    if (reproject(item, want)) pending_points.push_back(want);
  endtask

  function automatic dpr_in_t pixel(int d, int c, int r);
    dpr_in_t px;
    px.disparity_q4 = d[DISP_W-1:0];
    px.pixel_col    = c[PIX_W-1:0];
    px.pixel_row    = r[PIX_W-1:0];
    return px;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_reg(idx, val);
  endtask

  // full calibration load, plus one write past the list that must be ignored
  task automatic program_calibration(logic [CFG_DATA_W-1:0] fx, logic [CFG_DATA_W-1:0] fy,
                                     logic [CFG_DATA_W-1:0] cx, logic [CFG_DATA_W-1:0] cy,
                                     logic [CFG_DATA_W-1:0] bl, logic [CFG_DATA_W-1:0] nr,
                                     logic [CFG_DATA_W-1:0] fr);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_BASELINE, bl);
    write_reg(REG_NEAR, nr);
    write_reg(REG_FAR, fr);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic program_defaults();
    program_calibration(CFG_DATA_W'(FOCAL_X_RST), CFG_DATA_W'(FOCAL_Y_RST),
                        CFG_DATA_W'(CENTER_X_RST), CFG_DATA_W'(CENTER_Y_RST),
                        CFG_DATA_W'(BASELINE_RST), NEAR_RST, FAR_RST);
  endtask

  // stop sending, wait for every predicted point, then give the pipe time to
  // flush pixels that make no point; only ready cycles are counted
  task automatic wait_quiet();
    int ready_cycles;
    pix_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    ready_cycles = 0;
    while (ready_cycles < 2 * PIPE_LATENCY) begin
      @(posedge clk);
      if (pt_ready) ready_cycles++;
    end
  endtask

  // mostly camera-like calibrations, sometimes raw bits (upper bits test the masking)
  task automatic program_random_calibration();
    int nr;
    if ($urandom_range(0, 9) < 7) begin
      nr = $urandom_range(0, 3000000);
      program_calibration(CFG_DATA_W'($urandom_range(40000, 400000)),
                          CFG_DATA_W'($urandom_range(40000, 400000)),
                          CFG_DATA_W'($urandom_range(0, 1048575)),
                          CFG_DATA_W'($urandom_range(0, 1048575)),
                          CFG_DATA_W'($urandom_range(1000, 1000000)), CFG_DATA_W'(nr),
                          CFG_DATA_W'($urandom_range(nr + 1000, 100000000)));
    end else begin
      program_calibration(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                          CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                          CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                          CFG_DATA_W'($urandom()));
    end
  endtask

  // most pixels are kept and land inside the depth window; the rest are
  // dropped pixels, out-of-window depths, bad disparities and raw noise
  function automatic dpr_in_t random_pixel();
    dpr_in_t px;
    longint  target;
    longint  d;
    int      pick;
    px.pixel_col = PIX_W'($urandom());
    px.pixel_row = PIX_W'($urandom());
    if ($urandom_range(0, 9) < 8) begin
      px.pixel_col[0] = 1'b0;
      px.pixel_row[0] = 1'b0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60 && lim_far > lim_near + 1) begin
      // invert the depth formula around a depth inside the window
      target = longint'($urandom_range(lim_near + 1, lim_far - 1));
      d = (longint'(cal_fx) * longint'(cal_base)) / (16 * target);
      if (d < 1) d = 1;
      if (d > 32767) d = 32767;
      px.disparity_q4 = d[DISP_W-1:0];
    end else if (pick < 75) begin
      px.disparity_q4 = DISP_W'($urandom_range(1, 32767));
    end else if (pick < 85) begin
      px.disparity_q4 = DISP_W'(-int'($urandom_range(0, 32768)));
    end else begin
      px.disparity_q4 = DISP_W'($urandom());
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset calibration: field extremes, dropped pixels, bad and extreme disparities
  task automatic test_default_pixels();
    send_pixel(pixel(400, 0, 0));
    send_pixel(pixel(400, 4094, 4094));
    send_pixel(pixel(400, 640, 496));
    send_pixel(pixel(400, 4095, 0));     // odd column
    send_pixel(pixel(400, 0, 4095));     // odd row
    send_pixel(pixel(0, 2, 2));          // zero disparity
    send_pixel(pixel(-1, 4, 4));
    send_pixel(pixel(-32768, 6, 6));
    send_pixel(pixel(32767, 8, 8));      // too near
    send_pixel(pixel(1, 10, 10));        // depth beyond 27 bits, too far
    send_pixel(pixel(16, 12, 12));
    send_pixel(pixel('hAAAA, 2730, 1364));
  endtask

  // depth exactly on each limit is out, one step inside is in
  task automatic test_depth_window();
    logic [CFG_DATA_W-1:0] z_lo, z_hi, z_mid;
    wait_quiet();
    program_defaults();
    z_lo  = CFG_DATA_W'(depth_um(DISP_W'(500)));
    z_hi  = CFG_DATA_W'(depth_um(DISP_W'(300)));
    z_mid = CFG_DATA_W'(depth_um(DISP_W'(400)));
    program_calibration(CFG_DATA_W'(FOCAL_X_RST), CFG_DATA_W'(FOCAL_Y_RST),
                        CFG_DATA_W'(CENTER_X_RST), CFG_DATA_W'(CENTER_Y_RST),
                        CFG_DATA_W'(BASELINE_RST), z_lo, z_hi);
    send_pixel(pixel(500, 100, 60));
    send_pixel(pixel(499, 102, 62));
    send_pixel(pixel(300, 104, 64));
    send_pixel(pixel(301, 106, 66));
    // near not below far: nothing can qualify
    wait_quiet();
    program_calibration(CFG_DATA_W'(FOCAL_X_RST), CFG_DATA_W'(FOCAL_Y_RST),
                        CFG_DATA_W'(CENTER_X_RST), CFG_DATA_W'(CENTER_Y_RST),
                        CFG_DATA_W'(BASELINE_RST), z_mid, z_mid);
    send_pixel(pixel(400, 108, 68));
  endtask

  // register extremes: all zero, all ones, zero vertical focal, unit focal with masking
  task automatic test_register_extremes();
    wait_quiet();
    program_calibration('0, '0, '0, '0, '0, '0, '0);
    send_pixel(pixel(400, 0, 0));
    wait_quiet();
    program_calibration(27'hFFFFF, 27'hFFFFF, 27'hFFFFF, 27'hFFFFF, 27'hFFFFF,
                        '0, 27'h7FFFFFF);
    send_pixel(pixel(32767, 0, 0));
    send_pixel(pixel(32767, 4094, 4094));
    send_pixel(pixel(8192, 2048, 100));
    wait_quiet();
    // zero vertical focal divides by one, so y saturates both ways
    program_calibration(CFG_DATA_W'(FOCAL_X_RST), '0, CFG_DATA_W'(CENTER_X_RST),
                        CFG_DATA_W'(CENTER_Y_RST), CFG_DATA_W'(BASELINE_RST),
                        NEAR_RST, FAR_RST);
    send_pixel(pixel(400, 0, 0));
    send_pixel(pixel(400, 4094, 4094));
    wait_quiet();
    // bits above the 20-bit registers must be dropped
    program_calibration(27'h7F00001, {7'h7F, FOCAL_Y_RST}, 27'h7FFFFFF,
                        CFG_DATA_W'(CENTER_Y_RST), 27'd1000000, '0, 27'd100000000);
    send_pixel(pixel(1, 100, 100));
    send_pixel(pixel(2, 4094, 0));
  endtask

  // random calibrations, each followed by a block of random pixels
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        idle_tx = 1'b0;
        idle_rx = 1'b0;
      end
      wait_quiet();
      if (phase == 0) program_defaults();
      else program_random_calibration();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // idling switches change every 50 items, so some stretches run flat out
        if (n % 50 == 0 && phase != RANDOM_PHASES - 1) begin
          idle_tx = ($urandom_range(0, 3) != 0);
          idle_rx = ($urandom_range(0, 3) != 0);
        end
        send_pixel(random_pixel());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    pix       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    // predictor starts from the reset calibration
    cal_fx   = FOCAL_X_RST;
    cal_fy   = FOCAL_Y_RST;
    cal_cx   = CENTER_X_RST;
    cal_cy   = CENTER_Y_RST;
    cal_base = BASELINE_RST;
    lim_near = NEAR_RST;
    lim_far  = FAR_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_tx = 1'b1;
    idle_rx = 1'b1;
    test_default_pixels();
    test_depth_window();
    test_register_extremes();
    test_random_traffic();

    // drain everything, then let any stray point show up before judging
    wait_quiet();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/dpr_pkg.sv
rtl/dpr_div_pipe.sv
rtl/disparity_to_point_reprojector_core.sv
dv/tb_top.sv
